@@ src/pcrf_pkg.sv @@
// Package for the pixel color ratio feature block.
// Widths, spans, feature lane indices and the denominator helper.
// No dependencies.
package pcrf_pkg;

  localparam int NUM_W  = 9;
  localparam int DEN_W  = 16;
  localparam int OUT_W  = 16;
  localparam int FEAT_N = 12;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [OUT_W-1:0] feat_t;

  localparam den_t HUE_SPAN  = 16'd180;
  localparam den_t BYTE_SPAN = 16'd255;
  localparam den_t PAIR_SPAN = 16'd510;

  localparam int FT_HSV_SAT_NORM      = 0;
  localparam int FT_HSV_VAL_NORM      = 1;
  localparam int FT_HSV_HUE_PER_SAT   = 2;
  localparam int FT_HSV_HUE_PER_VAL   = 3;
  localparam int FT_HSV_SAT_PER_VAL   = 4;
  localparam int FT_HLS_LIGHT_NORM    = 5;
  localparam int FT_HLS_SAT_NORM      = 6;
  localparam int FT_HLS_HUE_PER_LIGHT = 7;
  localparam int FT_HLS_HUE_PER_SAT   = 8;
  localparam int FT_HLS_LIGHT_PER_SAT = 9;
  localparam int FT_BLUE_NORM         = 10;
  localparam int FT_GREEN_RED_NORM    = 11;

  // (x + 1) * span; at most 256 * 255, fits 16 bits
  function automatic den_t span_mul(logic [7:0] x, den_t span);
    den_t x1;
    x1 = {8'b0, x} + 16'd1;
    return x1 * span;
  endfunction

endpackage

@@ src/pixel_color_ratio_features.sv @@
// Top level: per-pixel shadow-detection color ratio features, Q0.FRACTION_BITS.
// Pipelined restoring divider, one lane per feature. Depends on pcrf_pkg.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid_i / in_ready_o | hsv_*, hls_*, blue, green, red (8b)
//   out     | out_valid_o/out_ready_i | twelve features (16b unsigned)
//
// One pixel per cycle sustained while out_ready_i is high. NSTG = ceil(QW / 2) divider
// stages, QW = min(FRACTION_BITS, 16), two quotient bits per stage; the chain is the input
// stage, the saturation check, the division stages and the output register.
// Reset clears only the stage valid bits. Each stage loads when it is empty or
// its successor loads, so bubbles close up and a stall holds every stage.
module pixel_color_ratio_features import pcrf_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  hsv_hue_i,
  input  logic [7:0]  hsv_saturation_i,
  input  logic [7:0]  hsv_value_i,
  input  logic [7:0]  hls_hue_i,
  input  logic [7:0]  hls_lightness_i,
  input  logic [7:0]  hls_saturation_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] hsv_sat_norm_o,
  output logic [15:0] hsv_val_norm_o,
  output logic [15:0] hsv_hue_per_sat_o,
  output logic [15:0] hsv_hue_per_val_o,
  output logic [15:0] hsv_sat_per_val_o,
  output logic [15:0] hls_light_norm_o,
  output logic [15:0] hls_sat_norm_o,
  output logic [15:0] hls_hue_per_light_o,
  output logic [15:0] hls_hue_per_sat_o,
  output logic [15:0] hls_light_per_sat_o,
  output logic [15:0] blue_norm_o,
  output logic [15:0] green_red_norm_o
);

  localparam int QW    = (FRACTION_BITS > OUT_W) ? OUT_W : FRACTION_BITS;
  localparam int SHIFT = FRACTION_BITS - QW;
  localparam int BPS   = 2;
  localparam int NSTG  = (QW + BPS - 1) / BPS;
  localparam int CMP_W = NUM_W + SHIFT + DEN_W;

  // input stage
  logic p0_v_q;
  logic p0_ld;
  num_t p0_num_q [FEAT_N];
  den_t p0_den_q [FEAT_N];
  num_t num_d    [FEAT_N];
  den_t den_d    [FEAT_N];

  // stage 0 is the saturation check, stages 1..NSTG the division steps
  logic [NSTG:0]   dv_q;
  logic [NSTG:0]   dld;
  den_t            rem_q [NSTG+1][FEAT_N];
  den_t            rem_d [NSTG+1][FEAT_N];
  den_t            dden_q [NSTG+1][FEAT_N];
  logic [QW-1:0]   quo_q [NSTG+1][FEAT_N];
  logic [QW-1:0]   quo_d [NSTG+1][FEAT_N];
  logic [FEAT_N-1:0] sat_q [NSTG+1];
  logic [FEAT_N-1:0] sat_d;

  // output stage
  logic  out_v_q;
  logic  out_ld;
  feat_t out_q [FEAT_N];

  assign out_ld = !out_v_q || out_ready_i;
  assign dld[NSTG] = !dv_q[NSTG] || out_ld;
  for (genvar k = 0; k < NSTG; k++) begin : g_ld
    assign dld[k] = !dv_q[k] || dld[k+1];
  end
  assign p0_ld      = !p0_v_q || dld[0];
  assign in_ready_o = p0_ld;

  always_comb begin
    num_d[FT_HSV_SAT_NORM]      = {1'b0, hsv_saturation_i};
    den_d[FT_HSV_SAT_NORM]      = BYTE_SPAN;
    num_d[FT_HSV_VAL_NORM]      = {1'b0, hsv_value_i};
    den_d[FT_HSV_VAL_NORM]      = BYTE_SPAN;
    num_d[FT_HSV_HUE_PER_SAT]   = {1'b0, hsv_hue_i};
    den_d[FT_HSV_HUE_PER_SAT]   = span_mul(hsv_saturation_i, HUE_SPAN);
    num_d[FT_HSV_HUE_PER_VAL]   = {1'b0, hsv_hue_i};
    den_d[FT_HSV_HUE_PER_VAL]   = span_mul(hsv_value_i, HUE_SPAN);
    num_d[FT_HSV_SAT_PER_VAL]   = {1'b0, hsv_saturation_i};
    den_d[FT_HSV_SAT_PER_VAL]   = span_mul(hsv_value_i, BYTE_SPAN);
    num_d[FT_HLS_LIGHT_NORM]    = {1'b0, hls_lightness_i};
    den_d[FT_HLS_LIGHT_NORM]    = BYTE_SPAN;
    num_d[FT_HLS_SAT_NORM]      = {1'b0, hls_saturation_i};
    den_d[FT_HLS_SAT_NORM]      = BYTE_SPAN;
    num_d[FT_HLS_HUE_PER_LIGHT] = {1'b0, hls_hue_i};
    den_d[FT_HLS_HUE_PER_LIGHT] = span_mul(hls_lightness_i, HUE_SPAN);
    num_d[FT_HLS_HUE_PER_SAT]   = {1'b0, hls_hue_i};
    den_d[FT_HLS_HUE_PER_SAT]   = span_mul(hls_saturation_i, HUE_SPAN);
    num_d[FT_HLS_LIGHT_PER_SAT] = {1'b0, hls_lightness_i};
    den_d[FT_HLS_LIGHT_PER_SAT] = span_mul(hls_saturation_i, BYTE_SPAN);
    num_d[FT_BLUE_NORM]         = {1'b0, blue_i};
    den_d[FT_BLUE_NORM]         = BYTE_SPAN;
    num_d[FT_GREEN_RED_NORM]    = {1'b0, green_i} + {1'b0, red_i};
    den_d[FT_GREEN_RED_NORM]    = PAIR_SPAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (p0_ld) begin
      p0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p0_ld) begin
      p0_num_q <= num_d;
      p0_den_q <= den_d;
    end
  end

  // saturate when num * 2^SHIFT >= den, else the quotient fits QW bits
  always_comb begin
    logic [CMP_W-1:0] nsh;
    for (int i = 0; i < FEAT_N; i++) begin
      nsh          = CMP_W'(p0_num_q[i]) << SHIFT;
      sat_d[i]     = nsh >= CMP_W'(p0_den_q[i]);
      rem_d[0][i]  = nsh[DEN_W-1:0];
      quo_d[0][i]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (dld[0]) begin
      dv_q[0] <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dld[0]) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      dden_q[0] <= p0_den_q;
      sat_q[0]  <= sat_d;
    end
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_div
    always_comb begin
      logic [DEN_W:0]  r2;
      den_t            r;
      logic [QW-1:0]   q;
      for (int i = 0; i < FEAT_N; i++) begin
        r = rem_q[k-1][i];
        q = quo_q[k-1][i];
        for (int j = 0; j < BPS; j++) begin
          if ((k - 1) * BPS + j < QW) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, dden_q[k-1][i]}) begin
              r2 = r2 - {1'b0, dden_q[k-1][i]};
              q  = {q[QW-2:0], 1'b1};
            end else begin
              q  = {q[QW-2:0], 1'b0};
            end
            r = r2[DEN_W-1:0];
          end
        end
        rem_d[k][i] = r;
        quo_d[k][i] = q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (dld[k]) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (dld[k]) begin
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        dden_q[k] <= dden_q[k-1];
        sat_q[k]  <= sat_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ld) begin
      out_v_q <= dv_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      for (int i = 0; i < FEAT_N; i++) begin
        out_q[i] <= sat_q[NSTG][i] ? OUT_W'({QW{1'b1}}) : OUT_W'(quo_q[NSTG][i]);
      end
    end
  end

  assign out_valid_o         = out_v_q;
  assign hsv_sat_norm_o      = out_q[FT_HSV_SAT_NORM];
  assign hsv_val_norm_o      = out_q[FT_HSV_VAL_NORM];
  assign hsv_hue_per_sat_o   = out_q[FT_HSV_HUE_PER_SAT];
  assign hsv_hue_per_val_o   = out_q[FT_HSV_HUE_PER_VAL];
  assign hsv_sat_per_val_o   = out_q[FT_HSV_SAT_PER_VAL];
  assign hls_light_norm_o    = out_q[FT_HLS_LIGHT_NORM];
  assign hls_sat_norm_o      = out_q[FT_HLS_SAT_NORM];
  assign hls_hue_per_light_o = out_q[FT_HLS_HUE_PER_LIGHT];
  assign hls_hue_per_sat_o   = out_q[FT_HLS_HUE_PER_SAT];
  assign hls_light_per_sat_o = out_q[FT_HLS_LIGHT_PER_SAT];
  assign blue_norm_o         = out_q[FT_BLUE_NORM];
  assign green_red_norm_o    = out_q[FT_GREEN_RED_NORM];

endmodule

@@ test/tb_pixel_color_ratio_features.sv @@
// Testbench for pixel_color_ratio_features: twelve Q0.16 color ratio features per pixel.
// Directed corners, then random pixels under four flow-control phases; checked in order.
// Depends on pcrf_pkg and the pixel_color_ratio_features RTL.
module tb_pixel_color_ratio_features import pcrf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] hsv_h;
    logic [7:0] hsv_s;
    logic [7:0] hsv_v;
    logic [7:0] hls_h;
    logic [7:0] hls_l;
    logic [7:0] hls_s;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  typedef feat_t [FEAT_N-1:0] feature_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  hsv_hue_i, hsv_saturation_i, hsv_value_i;
  logic [7:0]  hls_hue_i, hls_lightness_i, hls_saturation_i;
  logic [7:0]  blue_i, green_i, red_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  feature_set_t dut_features;

  feature_set_t expected_features[$];
  int unsigned  mismatch_count = 0;
  int unsigned  pixels_sent = 0;
  int unsigned  sets_checked = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  pixel_color_ratio_features #(.FRACTION_BITS(FRAC_BITS)) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .hsv_hue_i           (hsv_hue_i),
    .hsv_saturation_i    (hsv_saturation_i),
    .hsv_value_i         (hsv_value_i),
    .hls_hue_i           (hls_hue_i),
    .hls_lightness_i     (hls_lightness_i),
    .hls_saturation_i    (hls_saturation_i),
    .blue_i              (blue_i),
    .green_i             (green_i),
    .red_i               (red_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .hsv_sat_norm_o      (dut_features[FT_HSV_SAT_NORM]),
    .hsv_val_norm_o      (dut_features[FT_HSV_VAL_NORM]),
    .hsv_hue_per_sat_o   (dut_features[FT_HSV_HUE_PER_SAT]),
    .hsv_hue_per_val_o   (dut_features[FT_HSV_HUE_PER_VAL]),
    .hsv_sat_per_val_o   (dut_features[FT_HSV_SAT_PER_VAL]),
    .hls_light_norm_o    (dut_features[FT_HLS_LIGHT_NORM]),
    .hls_sat_norm_o      (dut_features[FT_HLS_SAT_NORM]),
    .hls_hue_per_light_o (dut_features[FT_HLS_HUE_PER_LIGHT]),
    .hls_hue_per_sat_o   (dut_features[FT_HLS_HUE_PER_SAT]),
    .hls_light_per_sat_o (dut_features[FT_HLS_LIGHT_PER_SAT]),
    .blue_norm_o         (dut_features[FT_BLUE_NORM]),
    .green_red_norm_o    (dut_features[FT_GREEN_RED_NORM])
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // floor(num * 2^FRAC_BITS / den), saturated to the top code
  function automatic feat_t clamped_ratio(longint unsigned num, longint unsigned den);
    longint unsigned top;
    longint unsigned q;
    top = (64'd1 << FRAC_BITS) - 64'd1;
    if (top > 64'hFFFF) top = 64'hFFFF;
    q = (num << FRAC_BITS) / den;
    return feat_t'((q > top) ? top : q);
  endfunction

  function automatic feature_set_t color_features(pixel_t px);
    feature_set_t f;
    f[FT_HSV_SAT_NORM]      = clamped_ratio(px.hsv_s, 255);
    f[FT_HSV_VAL_NORM]      = clamped_ratio(px.hsv_v, 255);
    f[FT_HSV_HUE_PER_SAT]   = clamped_ratio(px.hsv_h, (longint'(px.hsv_s) + 1) * 180);
    f[FT_HSV_HUE_PER_VAL]   = clamped_ratio(px.hsv_h, (longint'(px.hsv_v) + 1) * 180);
    f[FT_HSV_SAT_PER_VAL]   = clamped_ratio(px.hsv_s, (longint'(px.hsv_v) + 1) * 255);
    f[FT_HLS_LIGHT_NORM]    = clamped_ratio(px.hls_l, 255);
    f[FT_HLS_SAT_NORM]      = clamped_ratio(px.hls_s, 255);
    f[FT_HLS_HUE_PER_LIGHT] = clamped_ratio(px.hls_h, (longint'(px.hls_l) + 1) * 180);
    f[FT_HLS_HUE_PER_SAT]   = clamped_ratio(px.hls_h, (longint'(px.hls_s) + 1) * 180);
    f[FT_HLS_LIGHT_PER_SAT] = clamped_ratio(px.hls_l, (longint'(px.hls_s) + 1) * 255);
    f[FT_BLUE_NORM]         = clamped_ratio(px.b, 255);
    f[FT_GREEN_RED_NORM]    = clamped_ratio(longint'(px.g) + longint'(px.r), 510);
    return f;
  endfunction

  function automatic string feature_name(int k);
    case (k)
      FT_HSV_SAT_NORM:      return "hsv_sat_norm";
      FT_HSV_VAL_NORM:      return "hsv_val_norm";
      FT_HSV_HUE_PER_SAT:   return "hsv_hue_per_sat";
      FT_HSV_HUE_PER_VAL:   return "hsv_hue_per_val";
      FT_HSV_SAT_PER_VAL:   return "hsv_sat_per_val";
      FT_HLS_LIGHT_NORM:    return "hls_light_norm";
      FT_HLS_SAT_NORM:      return "hls_sat_norm";
      FT_HLS_HUE_PER_LIGHT: return "hls_hue_per_light";
      FT_HLS_HUE_PER_SAT:   return "hls_hue_per_sat";
      FT_HLS_LIGHT_PER_SAT: return "hls_light_per_sat";
      FT_BLUE_NORM:         return "blue_norm";
      default:              return "green_red_norm";
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // input monitor predicts; output monitor compares against the oldest prediction
  always @(posedge clk_i) begin
    pixel_t       px;
    feature_set_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        px = '{hsv_hue_i, hsv_saturation_i, hsv_value_i, hls_hue_i, hls_lightness_i,
               hls_saturation_i, blue_i, green_i, red_i};
        expected_features = {expected_features, color_features(px)};
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_features.size() == 0) begin
          report_mismatch("feature set with no pixel pending");
        end else begin
          want = expected_features.pop_front();
          for (int k = 0; k < FEAT_N; k++) begin
            if (dut_features[k] !== want[k])
              report_mismatch($sformatf("set %0d %s got %0d exp %0d", sets_checked,
                                        feature_name(k), dut_features[k], want[k]));
          end
          sets_checked++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sets pending", cycle_count,
               expected_features.size());
      $display("tb_pixel_color_ratio_features: errors");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    hsv_hue_i        <= px.hsv_h;
    hsv_saturation_i <= px.hsv_s;
    hsv_value_i      <= px.hsv_v;
    hls_hue_i        <= px.hls_h;
    hls_lightness_i  <= px.hls_l;
    hls_saturation_i <= px.hls_s;
    blue_i           <= px.b;
    green_i          <= px.g;
    red_i            <= px.r;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // hue mostly in 0..179, now and then the full byte
  function automatic logic [7:0] random_hue();
    case ($urandom_range(15))
      0:       return 8'($urandom_range(255));
      1:       return 8'd179;
      2:       return 8'd0;
      default: return 8'($urandom_range(179));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.hsv_h = random_hue();
    px.hsv_s = random_byte();
    px.hsv_v = random_byte();
    px.hls_h = random_hue();
    px.hls_l = random_byte();
    px.hls_s = random_byte();
    px.b     = random_byte();
    px.g     = random_byte();
    px.r     = random_byte();
    return px;
  endfunction

  task automatic send_random_pixels(int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_directed_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pixel('0);
    send_pixel('{8'd179, 8'd255, 8'd255, 8'd179, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('1);
    // s over (v+1)*255 reaches one; l over (s+1)*255 too
    send_pixel('{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    // largest in-range hue against the smallest denominator
    send_pixel('{8'd179, 8'd0, 8'd0, 8'd179, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0});
    // hue above 179 saturates the hue ratios
    send_pixel('{8'd180, 8'd0, 8'd0, 8'd180, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0});
    send_pixel('{8'd255, 8'd0, 8'd7, 8'd200, 8'd3, 8'd0, 8'd128, 8'd0, 8'd255});
    // zero hue numerators against the largest denominators
    send_pixel('{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255});
    send_pixel('{8'd1, 8'd254, 8'd254, 8'd1, 8'd254, 8'd254, 8'd254, 8'd254, 8'd1});
    for (int k = 0; k < 8; k++) begin
      send_pixel({9{8'(1 << k)}});
    end
    send_pixel({9{8'h55}});
    send_pixel('{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA});
    send_pixel('{8'd90, 8'd1, 8'd0, 8'd90, 8'd0, 8'd1, 8'd127, 8'd128, 8'd127});
  endtask

  task automatic test_streaming_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_pixels(250);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 72;
    recv_stall_pct = 0;
    send_random_pixels(250);
  endtask

  task automatic test_receiver_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 72;
    send_random_pixels(250);
  endtask

  task automatic test_mixed_flow();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    send_random_pixels(250);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    hsv_hue_i        = '0;
    hsv_saturation_i = '0;
    hsv_value_i      = '0;
    hls_hue_i        = '0;
    hls_lightness_i  = '0;
    hls_saturation_i = '0;
    blue_i           = '0;
    green_i          = '0;
    red_i            = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    test_streaming_back_to_back();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_flow();

    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    wait (expected_features.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_features.size() != 0)
      report_mismatch($sformatf("%0d feature sets never arrived", expected_features.size()));

    $display("summary: %0d pixels sent, %0d feature sets compared, %0d mismatches",
             pixels_sent, sets_checked, mismatch_count);
    $display("summary: corners plus random pixels, free flow, sender gaps, backpressure, mixed");
    if (mismatch_count == 0) begin
      $display("tb_pixel_color_ratio_features: clean");
    end else begin
      $display("tb_pixel_color_ratio_features: errors");
    end
    $finish;
  end

endmodule
